// ===== hw/rtl/gte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_pkg
// Shared field widths, command, status and register codes, and the result
// record of the graph traversal engine.
// ----------------------------------------------------------------------------
package gte_pkg;

	localparam int NODE_W  = 6;
	localparam int DEPTH_W = 6;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_A_W = 2;
	localparam int CFG_D_W = 7;

	localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [CFG_A_W-1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_SEARCH_MODE = 2'd1;

	typedef struct packed {
		logic [NODE_W-1:0]  visited_node;
		logic [DEPTH_W-1:0] depth;
		logic               last_result;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

// ===== hw/rtl/gte_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_req_if
// Command request channel: valid/ready with the command fields.
// ----------------------------------------------------------------------------
interface gte_req_if;
	logic                       valid;
	logic                       ready;
	logic [gte_pkg::CMD_W-1:0]  command;
	logic [gte_pkg::NODE_W-1:0] edge_from;
	logic [gte_pkg::NODE_W-1:0] edge_to;
	logic [gte_pkg::NODE_W-1:0] start_node;

	modport source (output valid, command, edge_from, edge_to, start_node, input ready);
	modport sink   (input valid, command, edge_from, edge_to, start_node, output ready);
endinterface

// ===== hw/rtl/gte_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_rsp_if
// Result channel: valid/ready with one visited node record.
// ----------------------------------------------------------------------------
interface gte_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [gte_pkg::NODE_W-1:0]  visited_node;
	logic [gte_pkg::DEPTH_W-1:0] depth;
	logic                        last_result;
	logic [gte_pkg::STAT_W-1:0]  status;

	modport source (output valid, visited_node, depth, last_result, status, input ready);
	modport sink   (input valid, visited_node, depth, last_result, status, output ready);
endinterface

// ===== hw/rtl/gte_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface gte_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [gte_pkg::CFG_A_W-1:0] addr;
	logic [gte_pkg::CFG_D_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/gte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
module gte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/graph_traversal_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_traversal_engine_core
// Directed graph store with breadth-first and depth-first traversal.
//
// Channels: req carries one command request (add edge, traverse, clear).
// rsp returns result records; the final record of a request has
// last_result set. cfg writes node_count (index 0) and search_mode
// (index 1); it is always ready. The user is to use it only while the
// engine is idle; the block itself does not enforce this. A clear goes
// straight to its result; an add edge does a tail lookup in the list RAM,
// the append and, for a non-empty list, a link patch. A traversal steps
// through the edges one by one, and the edge RAM read of each edge sets
// the pace. Requests are taken one at a time; a new one is accepted in
// the cycle after the final result enters the output register.
// Reset: all edge lists empty, no edges used, node_count 64, breadth-first.
// Stall: records are held back one deep so the last can be marked; when
// the receiver stalls, the traversal waits at the next record to emit.
// ----------------------------------------------------------------------------
module graph_traversal_engine_core #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	gte_req_if.sink   req,
	gte_rsp_if.source rsp,
	gte_cfg_if.sink   cfg
);

	localparam int NW = $clog2(MAX_NODES);       // node address
	localparam int CW = $clog2(MAX_NODES + 1);   // queue / stack count
	localparam int EW = $clog2(MAX_EDGES);       // edge index
	localparam int UW = $clog2(MAX_EDGES + 1);   // edges used
	localparam logic [UW-1:0] EDGES_FULL = UW'(MAX_EDGES);
	localparam logic [CW-1:0] NODES_FULL = CW'(MAX_NODES);
	localparam logic [gte_pkg::CFG_D_W-1:0] LIM_MAX = gte_pkg::CFG_D_W'(MAX_NODES);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_ADD_WR   = 14'b00000000000010,
		S_ADD_LINK = 14'b00000000000100,
		S_FIN      = 14'b00000000001000,
		S_B_POP    = 14'b00000000010000,
		S_B_NODE   = 14'b00000000100000,
		S_B_HEAD   = 14'b00000001000000,
		S_B_EDGE   = 14'b00000010000000,
		S_B_TGT    = 14'b00000100000000,
		S_D_INIT   = 14'b00001000000000,
		S_D_STEP   = 14'b00010000000000,
		S_D_TGT    = 14'b00100000000000,
		S_D_PUSH   = 14'b01000000000000,
		S_D_POPW   = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Configuration
	logic [gte_pkg::CFG_D_W-1:0] lim_q;
	logic                        mode_q;

	// Graph bookkeeping
	logic [MAX_NODES-1:0] nonempty_q;   // list valid per node
	logic [MAX_NODES-1:0] vis_q;
	logic [UW-1:0]        used_q;

	// Working registers
	logic [NW-1:0]              u_q;
	logic [gte_pkg::NODE_W-1:0] v_q;
	logic [gte_pkg::NODE_W-1:0] n_q;
	logic [EW-1:0]              e_q;
	logic                       ev_q;
	logic [EW-1:0]              tail_q;
	logic [gte_pkg::DEPTH_W-1:0] dn_q;
	logic [CW-1:0]              rd_q;
	logic [CW-1:0]              wr_q;
	logic [CW-1:0]              sp_q;
	logic                       ne_q;

	// Output register and one-deep hold stage
	gte_pkg::res_t out_q;
	logic          out_v_q;
	gte_pkg::res_t held_q;
	logic          held_v_q;

	// RAM ports
	logic            hl_we, hl_re;
	logic [NW-1:0]   hl_waddr, hl_raddr;
	logic [2*EW-1:0] hl_wdata, hl_rdata;
	logic            tg_we, tg_re;
	logic [EW-1:0]   tg_waddr, tg_raddr;
	logic [gte_pkg::NODE_W-1:0] tg_wdata, tg_rdata;
	logic            lk_we;
	logic [EW-1:0]   lk_waddr;
	logic [EW:0]     lk_wdata, lk_rdata;
	logic            wk_we, wk_re;
	logic [NW-1:0]   wk_waddr, wk_raddr;
	logic [gte_pkg::NODE_W-1:0] wk_wdata, wk_rdata;
	logic            dp_we, dp_re;
	logic [NW-1:0]   dp_waddr, dp_raddr;
	logic [gte_pkg::DEPTH_W-1:0] dp_wdata, dp_rdata;
	logic            cu_we, cu_re;
	logic [NW-1:0]   cu_waddr, cu_raddr;
	logic [EW:0]     cu_wdata, cu_rdata;

	// Request decode
	logic req_fire, out_free, can_emit, out_load;
	logic add_bad_range, add_full, start_bad;
	logic [gte_pkg::NODE_W-1:0] tgt;
	logic tgt_take_b, tgt_take_d;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;
	assign can_emit  = !held_v_q || out_free;

	assign add_bad_range = ({1'b0, req.edge_from} >= lim_q) || ({1'b0, req.edge_to} >= lim_q);
	assign add_full      = (used_q == EDGES_FULL);
	assign start_bad     = ({1'b0, req.start_node} >= lim_q);

	// Target of the edge just read; skip stale or visited nodes
	assign tgt = tg_rdata;
	assign tgt_take_b = ({1'b0, tgt} < lim_q) && !vis_q[tgt[NW-1:0]] && (wr_q != NODES_FULL);
	assign tgt_take_d = ({1'b0, tgt} < lim_q) && !vis_q[tgt[NW-1:0]] && (sp_q != NODES_FULL);

	// Advance a record into the output register
	assign out_load = (state_q == S_FIN && out_free)
		|| (state_q == S_B_HEAD && can_emit && held_v_q)
		|| (state_q == S_D_TGT && tgt_take_d && can_emit && held_v_q);

	assign rsp.valid        = out_v_q;
	assign rsp.visited_node = out_q.visited_node;
	assign rsp.depth        = out_q.depth;
	assign rsp.last_result  = out_q.last_result;
	assign rsp.status       = out_q.status;

	// Memory port steering
	always_comb begin
		hl_we = 1'b0; hl_waddr = u_q;
		hl_wdata = {(nonempty_q[u_q] ? hl_rdata[2*EW-1:EW] : e_q), e_q};
		hl_re = 1'b0; hl_raddr = req.edge_from[NW-1:0];
		tg_we = 1'b0; tg_waddr = e_q; tg_wdata = v_q;
		tg_re = 1'b0; tg_raddr = e_q;
		lk_we = 1'b0; lk_waddr = e_q; lk_wdata = '0;
		wk_we = 1'b0; wk_waddr = wr_q[NW-1:0]; wk_wdata = tgt;
		wk_re = 1'b0; wk_raddr = rd_q[NW-1:0];
		dp_we = 1'b0; dp_waddr = tgt[NW-1:0]; dp_wdata = dn_q + 1'b1;
		dp_re = 1'b0; dp_raddr = wk_rdata[NW-1:0];
		cu_we = 1'b0; cu_waddr = NW'(sp_q - 1'b1); cu_wdata = lk_rdata;
		cu_re = 1'b0; cu_raddr = NW'(sp_q - CW'(2));
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && req.command == gte_pkg::CMD_ADD) begin
					hl_re = 1'b1;
				end
				if (req_fire && req.command == gte_pkg::CMD_TRAVERSE && !start_bad) begin
					hl_raddr = req.start_node[NW-1:0];
					hl_re    = mode_q;
					wk_we    = !mode_q;
					wk_waddr = '0;
					wk_wdata = req.start_node;
					dp_we    = !mode_q;
					dp_waddr = req.start_node[NW-1:0];
					dp_wdata = '0;
				end
			end
			S_ADD_WR: begin
				hl_we = 1'b1;
				tg_we = 1'b1;
				lk_we = 1'b1;
			end
			S_ADD_LINK: begin
				lk_we    = 1'b1;
				lk_waddr = tail_q;
				lk_wdata = {1'b1, e_q};
			end
			S_B_POP: begin
				wk_re = (rd_q != wr_q);
			end
			S_B_NODE: begin
				hl_re    = 1'b1;
				hl_raddr = wk_rdata[NW-1:0];
				dp_re    = 1'b1;
			end
			S_B_EDGE: begin
				tg_re = ev_q;
			end
			S_B_TGT: begin
				wk_we = tgt_take_b;
				dp_we = tgt_take_b;
			end
			S_D_STEP: begin
				tg_raddr = e_q;
				tg_re    = ev_q;
				cu_re    = !ev_q && (sp_q != CW'(1));
			end
			S_D_TGT: begin
				if (tgt_take_d && can_emit) begin
					cu_we    = 1'b1;
					hl_re    = 1'b1;
					hl_raddr = tgt[NW-1:0];
				end
			end
			S_FIN, S_D_INIT, S_D_PUSH, S_D_POPW, S_B_HEAD: begin
			end
			default: begin
			end
		endcase
	end

	gte_ram #(.WIDTH(2*EW), .DEPTH(MAX_NODES)) u_hl_ram (
		.clk(clk), .we(hl_we), .waddr(hl_waddr), .wdata(hl_wdata),
		.re(hl_re), .raddr(hl_raddr), .rdata(hl_rdata)
	);

	gte_ram #(.WIDTH(gte_pkg::NODE_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
		.clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
		.re(tg_re), .raddr(tg_raddr), .rdata(tg_rdata)
	);

	// Link RAM reads alongside the target RAM
	gte_ram #(.WIDTH(EW+1), .DEPTH(MAX_EDGES)) u_link_ram (
		.clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.re(tg_re), .raddr(tg_raddr), .rdata(lk_rdata)
	);

	gte_ram #(.WIDTH(gte_pkg::NODE_W), .DEPTH(MAX_NODES)) u_work_ram (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.re(wk_re), .raddr(wk_raddr), .rdata(wk_rdata)
	);

	gte_ram #(.WIDTH(gte_pkg::DEPTH_W), .DEPTH(MAX_NODES)) u_depth_ram (
		.clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
		.re(dp_re), .raddr(dp_raddr), .rdata(dp_rdata)
	);

	gte_ram #(.WIDTH(EW+1), .DEPTH(MAX_NODES)) u_cursor_ram (
		.clk(clk), .we(cu_we), .waddr(cu_waddr), .wdata(cu_wdata),
		.re(cu_re), .raddr(cu_raddr), .rdata(cu_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lim_q      <= LIM_MAX;
			mode_q     <= 1'b0;
			nonempty_q <= '0;
			vis_q      <= '0;
			used_q     <= '0;
			u_q        <= '0;
			v_q        <= '0;
			n_q        <= '0;
			e_q        <= '0;
			ev_q       <= 1'b0;
			tail_q     <= '0;
			dn_q       <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			sp_q       <= '0;
			ne_q       <= 1'b0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
			held_q     <= '0;
			held_v_q   <= 1'b0;
		end else begin
			// Register writes; clamp the node limit to 1..MAX_NODES
			if (cfg.valid) begin
				if (cfg.addr == gte_pkg::CFG_NODE_COUNT) begin
					if (cfg.data == '0) begin
						lim_q <= gte_pkg::CFG_D_W'(1);
					end else if (cfg.data > LIM_MAX) begin
						lim_q <= LIM_MAX;
					end else begin
						lim_q <= cfg.data;
					end
				end else if (cfg.addr == gte_pkg::CFG_SEARCH_MODE) begin
					mode_q <= cfg.data[0];
				end
			end

			// Load a new output record, else drop the one taken
			out_v_q <= out_load || (out_v_q && !rsp.ready);

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						u_q <= req.edge_from[NW-1:0];
						v_q <= req.edge_to;
						e_q <= used_q[EW-1:0];
						case (req.command)
							gte_pkg::CMD_ADD: begin
								if (add_bad_range || add_full) begin
									held_q   <= '{'0, '0, 1'b1,
										add_bad_range ? gte_pkg::ST_RANGE : gte_pkg::ST_FULL};
									held_v_q <= 1'b1;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_ADD_WR;
								end
							end
							gte_pkg::CMD_CLEAR: begin
								nonempty_q <= '0;
								used_q     <= '0;
								held_q     <= '{'0, '0, 1'b1, gte_pkg::ST_OK};
								held_v_q   <= 1'b1;
								state_q    <= S_FIN;
							end
							gte_pkg::CMD_TRAVERSE: begin
								if (start_bad) begin
									held_q   <= '{'0, '0, 1'b1, gte_pkg::ST_RANGE};
									held_v_q <= 1'b1;
									state_q  <= S_FIN;
								end else begin
									// Clear all marks but the start node's
									vis_q <= {{(MAX_NODES-1){1'b0}}, 1'b1}
										<< req.start_node[NW-1:0];
									if (mode_q) begin
										// Depth-first: start node record goes into the hold stage at once
										held_q   <= '{req.start_node, '0, 1'b0, gte_pkg::ST_OK};
										held_v_q <= 1'b1;
										n_q      <= req.start_node;
										sp_q     <= CW'(1);
										state_q  <= S_D_INIT;
									end else begin
										rd_q    <= '0;
										wr_q    <= CW'(1);
										state_q <= S_B_POP;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end

				S_ADD_WR: begin
					nonempty_q[u_q] <= 1'b1;
					used_q          <= used_q + 1'b1;
					tail_q          <= hl_rdata[EW-1:0];
					if (nonempty_q[u_q]) begin
						state_q <= S_ADD_LINK;
					end else begin
						held_q   <= '{'0, '0, 1'b1, gte_pkg::ST_OK};
						held_v_q <= 1'b1;
						state_q  <= S_FIN;
					end
				end

				S_ADD_LINK: begin
					held_q   <= '{'0, '0, 1'b1, gte_pkg::ST_OK};
					held_v_q <= 1'b1;
					state_q  <= S_FIN;
				end

				S_FIN: begin
					// Release the held record as the final one
					if (out_free) begin
						out_q    <= '{held_q.visited_node, held_q.depth, 1'b1,
							held_q.status};
						held_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end

				S_B_POP: begin
					if (rd_q == wr_q) begin
						state_q <= S_FIN;
					end else begin
						rd_q    <= rd_q + 1'b1;
						state_q <= S_B_NODE;
					end
				end

				S_B_NODE: begin
					n_q     <= wk_rdata;
					state_q <= S_B_HEAD;
				end

				S_B_HEAD: begin
					if (can_emit) begin
						if (held_v_q) begin
							out_q <= held_q;
						end
						held_q   <= '{n_q, dp_rdata, 1'b0, gte_pkg::ST_OK};
						held_v_q <= 1'b1;
						dn_q     <= dp_rdata;
						e_q      <= hl_rdata[2*EW-1:EW];
						ev_q     <= nonempty_q[n_q[NW-1:0]];
						state_q  <= S_B_EDGE;
					end
				end

				S_B_EDGE: begin
					state_q <= ev_q ? S_B_TGT : S_B_POP;
				end

				S_B_TGT: begin
					if (tgt_take_b) begin
						vis_q[tgt[NW-1:0]] <= 1'b1;
						wr_q               <= wr_q + 1'b1;
					end
					ev_q    <= lk_rdata[EW];
					e_q     <= lk_rdata[EW-1:0];
					state_q <= S_B_EDGE;
				end

				S_D_INIT: begin
					ev_q    <= nonempty_q[n_q[NW-1:0]];
					e_q     <= hl_rdata[2*EW-1:EW];
					state_q <= S_D_STEP;
				end

				S_D_STEP: begin
					if (ev_q) begin
						state_q <= S_D_TGT;
					end else if (sp_q == CW'(1)) begin
						state_q <= S_FIN;
					end else begin
						// Backtrack: fetch the parent's cursor
						sp_q    <= sp_q - 1'b1;
						state_q <= S_D_POPW;
					end
				end

				S_D_TGT: begin
					if (tgt_take_d) begin
						if (can_emit) begin
							if (held_v_q) begin
								out_q <= held_q;
							end
							held_q   <= '{tgt, sp_q[gte_pkg::DEPTH_W-1:0], 1'b0, gte_pkg::ST_OK};
							held_v_q <= 1'b1;
							vis_q[tgt[NW-1:0]] <= 1'b1;
							ne_q     <= nonempty_q[tgt[NW-1:0]];
							sp_q     <= sp_q + 1'b1;
							state_q  <= S_D_PUSH;
						end
					end else begin
						ev_q    <= lk_rdata[EW];
						e_q     <= lk_rdata[EW-1:0];
						state_q <= S_D_STEP;
					end
				end

				S_D_PUSH: begin
					ev_q    <= ne_q;
					e_q     <= hl_rdata[2*EW-1:EW];
					state_q <= S_D_STEP;
				end

				S_D_POPW: begin
					ev_q    <= cu_rdata[EW];
					e_q     <= cu_rdata[EW-1:0];
					state_q <= S_D_STEP;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Nothing may be held back once a request has completed
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !held_v_q)
		else $error("held record left over in idle");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= EDGES_FULL)
		else $error("edge count beyond store size");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_POP || state_q == S_B_EDGE || state_q == S_B_TGT) |-> (rd_q <= wr_q))
		else $error("queue read pointer passed write pointer");

	a_stack_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D_STEP || state_q == S_D_TGT || state_q == S_D_PUSH) |-> (sp_q != '0))
		else $error("depth-first stack empty while searching");

	a_fin_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_v_q && out_q.last_result))
		else $error("final record not marked");

endmodule
